// File: hw/rtl/reorder_buffer_receiver_assert.svh
// ----------------------------------------------------------------------------
// Reorder buffer receiver assertion macros
// Shared property forms for the concurrent checks of the receiver.
// ----------------------------------------------------------------------------
`ifndef REORDER_BUFFER_RECEIVER_ASSERT_SVH
`define REORDER_BUFFER_RECEIVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("reorder buffer receiver: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("reorder buffer receiver: next-cycle check failed");

`endif

// File: hw/rtl/rbr_pkg.sv
// ----------------------------------------------------------------------------
// Reorder buffer receiver package
// Field widths, register indexes, result codes and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rbr_pkg;

    // Field widths
    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned HANDLE_W   = 32;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    // Defaults
    localparam int unsigned WINDOW_DEFAULT = 32;
    localparam logic [SEQ_W-1:0] END_SEQ_RESET     = 32'hFFFF_FFFF;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 16'd32768;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_END_SEQ     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 8'd1;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_REJECT  = 2'd2
    } rbr_kind_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic classify;
        logic ack_step;
        logic drain_take;
        logic drain_skip;
        logic finish;
    } rbr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_order;
        logic can_push;
        logic slot_valid;
        logic slot_nonzero;
        logic guard_done;
    } rbr_sts_t;

endpackage

// File: hw/rtl/rbr_if.sv
// ----------------------------------------------------------------------------
// Reorder buffer receiver channel interfaces
// Packet descriptor input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface rbr_pkt_if;
    import rbr_pkg::*;

    logic                valid;
    logic                ready;
    logic [SEQ_W-1:0]    seq_num;
    logic [LEN_W-1:0]    payload_len;
    logic [HANDLE_W-1:0] payload_handle;

    modport source (output valid, seq_num, payload_len, payload_handle, input ready);
    modport sink (input valid, seq_num, payload_len, payload_handle, output ready);
endinterface

interface rbr_res_if;
    import rbr_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   result_kind;
    logic [SEQ_W-1:0]    out_seq;
    logic [LEN_W-1:0]    out_len;
    logic [HANDLE_W-1:0] out_handle;
    logic                stream_end;
    logic                last;

    modport source (output valid, result_kind, out_seq, out_len, out_handle, stream_end,
                    last, input ready);
    modport sink (input valid, result_kind, out_seq, out_len, out_handle, stream_end,
                  last, output ready);
endinterface

interface rbr_cfg_if;
    import rbr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/rbr_controller.sv
// ----------------------------------------------------------------------------
// Reorder buffer receiver controller
// Sequences one packet descriptor at a time: classify, ack and drain (in-order packets only), finish.
// ----------------------------------------------------------------------------
module rbr_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rbr_pkg::rbr_sts_t sts,
    output rbr_pkg::rbr_cmd_t cmd
);
    import rbr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_CLASSIFY = 5'b00010,
        ST_ACK      = 5'b00100,
        ST_DRAIN    = 5'b01000,
        ST_FINISH   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // A new descriptor is taken only between items.
    assign in_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                state_next   = sts.in_order ? ST_ACK : ST_FINISH;
            end
            ST_ACK:
            begin
                if (sts.can_push)
                begin
                    cmd.ack_step = 1'b1;
                    state_next   = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.slot_valid || sts.guard_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (!sts.slot_nonzero)
                begin
                    cmd.drain_skip = 1'b1;
                end
                else if (sts.can_push)
                begin
                    cmd.drain_take = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (sts.can_push)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/rbr_datapath.sv
// ----------------------------------------------------------------------------
// Reorder buffer receiver datapath
// Configuration registers, expected sequence tracking, slot valid bits, the
// descriptor memory, a one-deep pending result and the output register.
// ----------------------------------------------------------------------------
`include "reorder_buffer_receiver_assert.svh"

module rbr_datapath #(
    parameter int unsigned WINDOW = rbr_pkg::WINDOW_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [rbr_pkg::SEQ_W-1:0]        seq_num,
    input  logic [rbr_pkg::LEN_W-1:0]        payload_len,
    input  logic [rbr_pkg::HANDLE_W-1:0]     payload_handle,
    input  logic                             cfg_we,
    input  logic [rbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [rbr_pkg::KIND_W-1:0]       result_kind,
    output logic [rbr_pkg::SEQ_W-1:0]        out_seq,
    output logic [rbr_pkg::LEN_W-1:0]        out_len,
    output logic [rbr_pkg::HANDLE_W-1:0]     out_handle,
    output logic                             stream_end,
    output logic                             last,
    input  rbr_pkg::rbr_cmd_t                cmd,
    output rbr_pkg::rbr_sts_t                sts
);
    import rbr_pkg::*;

    localparam int unsigned IDX_W   = $clog2(WINDOW);
    localparam int unsigned GUARD_W = $clog2(WINDOW + 1);
    localparam int unsigned ENTRY_W = LEN_W + HANDLE_W;
    localparam logic [SEQ_W-1:0]   WINDOW_SEQ = SEQ_W'(WINDOW);
    localparam logic [IDX_W:0]     WINDOW_SUM = (IDX_W + 1)'(WINDOW);
    localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(WINDOW - 1);
    localparam logic [GUARD_W-1:0] GUARD_FULL = GUARD_W'(WINDOW);

    // Configuration registers
    logic [SEQ_W-1:0] end_seq_reg;
    logic [LEN_W-1:0] max_payload_reg;

    // Latched descriptor
    logic [SEQ_W-1:0]    seq_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [HANDLE_W-1:0] handle_reg;

    // Stream state
    logic [SEQ_W-1:0]   expected_reg, expected_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [WINDOW-1:0]  valid_reg, valid_next;
    logic [GUARD_W-1:0] guard_reg, guard_next;
    logic               closing_reg, closing_next;

    // Descriptor memory
    logic [ENTRY_W-1:0] slot_mem [WINDOW];
    logic [ENTRY_W-1:0] rd_entry_reg;
    logic [LEN_W-1:0]    rd_len;
    logic [HANDLE_W-1:0] rd_handle;

    // Pending result and output register
    rbr_kind_t           pend_kind_reg;
    logic [SEQ_W-1:0]    pend_seq_reg;
    logic [LEN_W-1:0]    pend_len_reg;
    logic [HANDLE_W-1:0] pend_handle_reg;
    logic                out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]   out_kind_reg;
    logic [SEQ_W-1:0]    out_seq_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic                out_end_reg;
    logic                out_last_reg;

    // Classification wires
    logic [SEQ_W-1:0] diff;
    logic             is_dup;
    logic             too_long;
    logic             beyond;
    logic             pkt_ok;
    logic             in_order;
    logic [IDX_W:0]   slot_sum;
    logic [IDX_W:0]   slot_wrap;
    logic [IDX_W-1:0] store_idx;
    logic             do_store;
    logic             advance;
    logic             push;
    logic             can_push;
    logic             close_now;
    logic [SEQ_W-1:0] expected_inc;
    logic [IDX_W-1:0] idx_inc;

    // Configuration writes; indexes off the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_seq_reg     <= END_SEQ_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_END_SEQ)
            begin
                end_seq_reg <= cfg_data[SEQ_W-1:0];
            end
            if (cfg_index == CFG_MAX_PAYLOAD)
            begin
                max_payload_reg <= cfg_data[LEN_W-1:0];
            end
        end
    end

    // Descriptor latch.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            seq_reg    <= seq_num;
            len_reg    <= payload_len;
            handle_reg <= payload_handle;
        end
    end

    // Classify the latched descriptor against the expected sequence number.
    assign diff     = seq_reg - expected_reg;
    assign is_dup   = (seq_reg < expected_reg);
    assign too_long = (len_reg > max_payload_reg);
    assign beyond   = (diff >= WINDOW_SEQ);
    assign pkt_ok   = !is_dup && !too_long && !beyond;
    assign in_order = pkt_ok && (diff == '0);

    // Slot of an out-of-order packet: the offset stays below the window.
    assign slot_sum  = {1'b0, idx_reg} + {1'b0, diff[IDX_W-1:0]};
    assign slot_wrap = slot_sum - WINDOW_SUM;
    assign store_idx = (slot_sum >= WINDOW_SUM) ? slot_wrap[IDX_W-1:0] : slot_sum[IDX_W-1:0];
    assign do_store  = cmd.classify && pkt_ok && !in_order && !valid_reg[store_idx];

    // The slot index follows the expected number and restarts when it wraps.
    assign expected_inc = expected_reg + 1'b1;
    assign idx_inc      = ((expected_reg == '1) || (idx_reg == IDX_LAST)) ? '0
                                                                          : idx_reg + 1'b1;
    assign advance   = cmd.ack_step || cmd.drain_take || cmd.drain_skip;
    assign close_now = cmd.finish && closing_reg;
    assign push      = cmd.ack_step || cmd.drain_take || cmd.finish;
    assign can_push  = !out_valid_reg || out_ready;

    // Stream state next values.
    always_comb
    begin
        expected_next = expected_reg;
        idx_next      = idx_reg;
        valid_next    = valid_reg;
        guard_next    = guard_reg;
        closing_next  = closing_reg;
        if (cmd.classify)
        begin
            closing_next = pkt_ok && (seq_reg == end_seq_reg);
        end
        if (do_store)
        begin
            valid_next[store_idx] = 1'b1;
        end
        if (cmd.drain_take || cmd.drain_skip)
        begin
            valid_next[idx_reg] = 1'b0;
            guard_next          = guard_reg + 1'b1;
        end
        if (cmd.ack_step)
        begin
            guard_next = '0;
        end
        if (advance)
        begin
            expected_next = expected_inc;
            idx_next      = idx_inc;
        end
        if (close_now)
        begin
            expected_next = '0;
            idx_next      = '0;
            valid_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            idx_reg      <= '0;
            valid_reg    <= '0;
            guard_reg    <= '0;
            closing_reg  <= 1'b0;
        end
        else
        begin
            expected_reg <= expected_next;
            idx_reg      <= idx_next;
            valid_reg    <= valid_next;
            guard_reg    <= guard_next;
            closing_reg  <= closing_next;
        end
    end

    // Descriptor memory: one write port, one registered read at the next index.
    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            slot_mem[store_idx] <= {len_reg, handle_reg};
        end
        rd_entry_reg <= slot_mem[idx_next];
    end

    assign rd_len    = rd_entry_reg[ENTRY_W-1:HANDLE_W];
    assign rd_handle = rd_entry_reg[HANDLE_W-1:0];

    // Pending result: held until the next one shows whether it is the last.
    always_ff @(posedge clk)
    begin
        if (cmd.classify)
        begin
            pend_seq_reg <= seq_reg;
            if (in_order)
            begin
                pend_kind_reg   <= KIND_DELIVER;
                pend_len_reg    <= len_reg;
                pend_handle_reg <= handle_reg;
            end
            else
            begin
                pend_kind_reg   <= (!is_dup && !pkt_ok) ? KIND_REJECT : KIND_ACK;
                pend_len_reg    <= '0;
                pend_handle_reg <= '0;
            end
        end
        else if (cmd.ack_step)
        begin
            pend_kind_reg   <= KIND_ACK;
            pend_seq_reg    <= seq_reg;
            pend_len_reg    <= '0;
            pend_handle_reg <= '0;
        end
        else if (cmd.drain_take)
        begin
            pend_kind_reg   <= KIND_DELIVER;
            pend_seq_reg    <= expected_reg;
            pend_len_reg    <= rd_len;
            pend_handle_reg <= rd_handle;
        end
    end

    // Output register: a transfer frees it for the next pushed result.
    assign out_valid_next = push ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_kind_reg   <= pend_kind_reg;
            out_seq_reg    <= pend_seq_reg;
            out_len_reg    <= pend_len_reg;
            out_handle_reg <= pend_handle_reg;
            out_end_reg    <= closing_reg;
            out_last_reg   <= cmd.finish;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign out_seq     = out_seq_reg;
    assign out_len     = out_len_reg;
    assign out_handle  = out_handle_reg;
    assign stream_end  = out_end_reg;
    assign last        = out_last_reg;

    // Status to the controller.
    assign sts.in_order     = in_order;
    assign sts.can_push     = can_push;
    assign sts.slot_valid   = valid_reg[idx_reg];
    assign sts.slot_nonzero = (rd_len != '0);
    assign sts.guard_done   = (guard_reg == GUARD_FULL);

    // Checks
    `RBR_ASSERT_NOW(a_push_has_room, clk, rst_n, push, can_push)
    `RBR_ASSERT_NOW(a_idx_in_window, clk, rst_n, 1'b1, ({1'b0, idx_reg} < WINDOW_SUM))
    `RBR_ASSERT_NOW(a_drain_on_valid, clk, rst_n, (cmd.drain_take || cmd.drain_skip), valid_reg[idx_reg])
    `RBR_ASSERT_NEXT(a_close_clears, clk, rst_n, close_now, ((expected_reg == '0) && (valid_reg == '0)))

endmodule

// File: hw/rtl/reorder_buffer_receiver.sv
// ----------------------------------------------------------------------------
// Reorder buffer receiver
// Selective-repeat receive side: acks, in-order delivery and reordering of
// packet descriptors over a window of buffered slots.
// ----------------------------------------------------------------------------
// Usage:
//   pkt carries one packet descriptor per transfer (sequence number, length,
//   buffer handle). res carries the results it causes: acks, in-order
//   deliveries and rejects, with last set on the final result of a packet
//   and stream_end set on all results of the packet that closes the stream.
//   cfg writes end_seq (index 0) and max_payload (index 1); it is always
//   ready. It is to be written by the user only while no packet is in flight;
//   the block itself does not enforce this. One descriptor is handled at a time.
//   A duplicate, reject or out-of-order packet passes from the latch in idle
//   through classify to finish, which pushes its result into the output
//   register; an in-order packet goes through classify, ack, a drain walk
//   over the buffered slots and finish. The slot walk is set by the single
//   read port of the descriptor memory, one slot per cycle while res is not
//   stalled. pkt.ready is high again in the cycle right after the last
//   result is loaded into the output register.
//   Reset sets expected sequence to zero, clears all slot valid bits at once
//   and loads the register defaults; no clearing pass is needed. When res is
//   stalled the block holds its result and waits before each push.
// ----------------------------------------------------------------------------
module reorder_buffer_receiver #(
    parameter int unsigned WINDOW = rbr_pkg::WINDOW_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    rbr_pkt_if.sink   pkt,
    rbr_res_if.source res,
    rbr_cfg_if.sink   cfg
);
    import rbr_pkg::*;

    rbr_cmd_t cmd;
    rbr_sts_t sts;
    logic     in_ready;

    assign pkt.ready = in_ready;
    assign cfg.ready = 1'b1;

    // Control sequencer
    rbr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pkt.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    rbr_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .seq_num        (pkt.seq_num),
        .payload_len    (pkt.payload_len),
        .payload_handle (pkt.payload_handle),
        .cfg_we         (cfg.valid && cfg.ready),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_ready      (res.ready),
        .out_valid      (res.valid),
        .result_kind    (res.result_kind),
        .out_seq        (res.out_seq),
        .out_len        (res.out_len),
        .out_handle     (res.out_handle),
        .stream_end     (res.stream_end),
        .last           (res.last),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule
